// ----- sv/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg: stitch cycle sequencer shared types and constants
// Request and result payloads, configuration and state records, phase codes,
// and the fixed numbers used by the threshold tests.
// ----------------------------------------------------------------------------
package scs_pkg;

	// position replies use the low POSITION_BITS bits, two's complement
	localparam int POSITION_BITS = 32;
	localparam int POS_SHIFT     = 32 - POSITION_BITS;

	// config register indexes
	localparam logic [1:0] CFG_LINE_RANGE     = 2'd0;
	localparam logic [1:0] CFG_ROTATION_RANGE = 2'd1;
	localparam logic [1:0] CFG_SPEED_SCALE    = 2'd2;

	localparam logic [19:0] LINE_RANGE_RST     = 20'd750;
	localparam logic [19:0] ROTATION_RANGE_RST = 20'd92000;
	localparam logic [6:0]  SPEED_SCALE_RST    = 7'd5;

	// velocity = floor(speed * 16 / 10) = (speed * 6554) >> 12, exact for the 7-bit speed (< 128)
	localparam logic [19:0] VEL_RECIP = 20'd6554;
	localparam int          VEL_SHIFT = 12;

	// threshold scale factors, all in percent
	localparam logic signed [39:0] PCT_SCALE    = 40'sd100;
	localparam logic signed [39:0] JAW_CLOSED   = 40'sd6;
	localparam logic signed [39:0] JAW_OPEN     = 40'sd94;
	localparam logic signed [39:0] NEEDLE_FAR   = 40'sd96;
	localparam logic signed [39:0] NEEDLE_NEAR  = 40'sd4;

	localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
	localparam logic signed [31:0] TEMP_MIN = -32'sd32768;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_AUTO   = 2'd1,
		CMD_SINGLE = 2'd2,
		CMD_STOP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		QRY_NONE  = 3'd0,
		QRY_POS0  = 3'd1,
		QRY_POS1  = 3'd2,
		QRY_TEMP0 = 3'd3,
		QRY_TEMP1 = 3'd4
	} query_t;

	typedef enum logic [1:0] {
		MOT_NONE   = 2'd0,
		MOT_JAWVEL = 2'd1,
		MOT_NDLPOS = 2'd2
	} motion_t;

	typedef enum logic [1:0] {
		DRV_NONE    = 2'd0,
		DRV_ENABLE  = 2'd1,
		DRV_DISABLE = 2'd2
	} drive_t;

	typedef enum logic [3:0] {
		PH_FIND_JAW   = 4'd0,
		PH_CLOSE_CMD  = 4'd1,
		PH_CLOSE_WAIT = 4'd2,
		PH_NDL_CMD    = 4'd3,
		PH_NDL_WAIT   = 4'd4,
		PH_OPEN_CMD   = 4'd5,
		PH_OPEN_WAIT  = 4'd6,
		PH_TEMP_JAW   = 4'd7,
		PH_TEMP_NDL   = 4'd8,
		PH_DONE       = 4'd9
	} phase_t;

	typedef struct packed {
		logic [1:0]         command;
		logic               pedal;
		logic               reply_valid;
		logic signed [31:0] reply_value;
	} scs_in_t;

	typedef struct packed {
		logic [2:0]         query_kind;
		logic [1:0]         motion_kind;
		logic signed [31:0] motion_value;
		logic [1:0]         drive_command;
		logic [3:0]         phase;
		logic               stitch_done;
		logic               active;
		logic signed [15:0] jaw_temperature;
		logic signed [15:0] needle_temperature;
	} scs_out_t;

	typedef struct packed {
		logic [19:0] line_range;
		logic [19:0] rotation_range;
		logic [6:0]  speed_scale;
	} scs_cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic               needle_fwd;
		logic               armed;
		logic               stop_pending;
		logic               running;
		logic               single_mode;
		logic signed [15:0] jaw_temp;
		logic signed [15:0] needle_temp;
	} scs_state_t;

endpackage

// ----- sv/scs_step.sv -----
// ----------------------------------------------------------------------------
// scs_step: one sequencer step
// Combinational next state and result for one request, given the current
// state and configuration.
// ----------------------------------------------------------------------------
module scs_step import scs_pkg::*; (
	input  scs_cfg_t   cfg,
	input  scs_state_t cur,
	input  scs_in_t    req,
	output scs_state_t nxt,
	output scs_out_t   res
);

	logic signed [31:0] pos;
	logic signed [39:0] pos_x;
	logic signed [39:0] line_x;
	logic signed [39:0] rot_x;
	logic signed [39:0] pos_pct;
	logic [19:0]        vel_prod;
	logic signed [31:0] vel;
	logic signed [31:0] temp_sat;
	logic               jaw_closed;
	logic               jaw_open;
	logic               needle_there;

	// phase engine results
	phase_t             eff_phase;
	phase_t             rp_phase;
	query_t             rp_query;
	motion_t            rp_motion;
	logic signed [31:0] rp_mval;
	logic               rp_flip;
	logic               rp_jaw_we;
	logic               rp_ndl_we;

	logic   run_en;
	logic   done;
	cmd_t   cmd;

	assign cmd = cmd_t'(req.command);

	// sign extend the low position bits
	assign pos     = $signed(req.reply_value <<< POS_SHIFT) >>> POS_SHIFT;
	assign pos_x   = 40'(pos);
	assign line_x  = $signed({20'd0, cfg.line_range});
	assign rot_x   = $signed({20'd0, cfg.rotation_range});
	assign pos_pct = pos_x * PCT_SCALE;

	assign jaw_closed   = pos_pct < line_x * JAW_CLOSED;
	assign jaw_open     = pos_pct > line_x * JAW_OPEN;
	assign needle_there = cur.needle_fwd ? (pos_pct < -(rot_x * NEEDLE_FAR))
	                                     : (pos_pct > -(rot_x * NEEDLE_NEAR));

	assign vel_prod = {13'd0, cfg.speed_scale} * VEL_RECIP;
	assign vel      = $signed({24'd0, vel_prod[VEL_SHIFT +: 8]});

	always_comb begin
		if (req.reply_value > TEMP_MAX) begin
			temp_sat = TEMP_MAX;
		end else if (req.reply_value < TEMP_MIN) begin
			temp_sat = TEMP_MIN;
		end else begin
			temp_sat = req.reply_value;
		end
	end

	// phase engine; finding the jaw falls straight through into the close command once a reply is valid
	always_comb begin
		rp_query  = QRY_NONE;
		rp_motion = MOT_NONE;
		rp_mval   = '0;
		rp_flip   = 1'b0;
		rp_jaw_we = 1'b0;
		rp_ndl_we = 1'b0;
		eff_phase = cur.phase;
		if (cur.phase == PH_FIND_JAW) begin
			rp_query = QRY_POS0;
			if (req.reply_valid) begin
				eff_phase = PH_CLOSE_CMD;
			end
		end
		rp_phase = eff_phase;
		case (eff_phase)
			PH_CLOSE_CMD: begin
				rp_motion = MOT_JAWVEL;
				rp_mval   = -vel;
				rp_phase  = PH_CLOSE_WAIT;
			end
			PH_CLOSE_WAIT: begin
				rp_query = QRY_POS0;
				if (req.reply_valid && jaw_closed) begin
					rp_phase = PH_NDL_CMD;
				end
			end
			PH_NDL_CMD: begin
				rp_motion = MOT_NDLPOS;
				rp_mval   = cur.needle_fwd ? -$signed({12'd0, cfg.rotation_range}) : '0;
				rp_phase  = PH_NDL_WAIT;
			end
			PH_NDL_WAIT: begin
				rp_query = QRY_POS1;
				if (req.reply_valid && needle_there) begin
					rp_phase = PH_OPEN_CMD;
				end
			end
			PH_OPEN_CMD: begin
				rp_motion = MOT_JAWVEL;
				rp_mval   = vel;
				rp_phase  = PH_OPEN_WAIT;
			end
			PH_OPEN_WAIT: begin
				rp_query = QRY_POS0;
				if (req.reply_valid && jaw_open) begin
					rp_phase = PH_TEMP_JAW;
					rp_flip  = 1'b1;
				end
			end
			PH_TEMP_JAW: begin
				rp_query = QRY_TEMP0;
				if (req.reply_valid) begin
					rp_jaw_we = 1'b1;
					rp_phase  = PH_TEMP_NDL;
				end
			end
			PH_TEMP_NDL: begin
				rp_query = QRY_TEMP1;
				if (req.reply_valid) begin
					rp_ndl_we = 1'b1;
					rp_phase  = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign run_en = (cmd == CMD_TICK) && cur.running &&
	                (cur.single_mode || (req.pedal && cur.armed));
	assign done   = run_en && (cur.single_mode ? (rp_phase == PH_DONE)
	                                           : (rp_phase == PH_TEMP_JAW));

	// next state
	always_comb begin
		nxt = cur;
		case (cmd)
			CMD_AUTO: begin
				nxt.armed       = 1'b1;
				nxt.running     = 1'b1;
				nxt.single_mode = 1'b0;
			end
			CMD_SINGLE: begin
				nxt.running     = 1'b1;
				nxt.single_mode = 1'b1;
			end
			CMD_STOP: begin
				nxt.stop_pending = 1'b1;
			end
			default: begin
				if (run_en) begin
					nxt.phase = rp_phase;
					if (rp_flip) begin
						nxt.needle_fwd = ~cur.needle_fwd;
					end
					if (rp_jaw_we) begin
						nxt.jaw_temp = 16'(temp_sat);
					end
					if (rp_ndl_we) begin
						nxt.needle_temp = 16'(temp_sat);
					end
					if (done) begin
						nxt.phase = PH_FIND_JAW;
						if (cur.single_mode) begin
							nxt.running = 1'b0;
						end else begin
							nxt.armed = 1'b0;
							if (cur.stop_pending) begin
								nxt.running = 1'b0;
							end
						end
					end
				end else if (cur.running && !cur.single_mode && !req.pedal) begin
					nxt.armed = 1'b1;
				end
			end
		endcase
	end

	// result fields
	always_comb begin
		res.query_kind         = run_en ? rp_query : QRY_NONE;
		res.motion_kind        = run_en ? rp_motion : MOT_NONE;
		res.motion_value       = run_en ? rp_mval : '0;
		res.phase              = nxt.phase;
		res.stitch_done        = done;
		res.active             = nxt.running;
		res.jaw_temperature    = nxt.jaw_temp;
		res.needle_temperature = nxt.needle_temp;
		if (cmd == CMD_AUTO || cmd == CMD_SINGLE) begin
			res.drive_command = DRV_ENABLE;
		end else if (done && cur.single_mode) begin
			res.drive_command = DRV_DISABLE;
		end else begin
			res.drive_command = DRV_NONE;
		end
	end

endmodule

// ----- sv/stitch_cycle_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// stitch_cycle_sequencer_unit: two-motor stitch sequencer
// Steps the jaw/needle stitch sequence at most once per request and returns the query,
// motion and drive commands for that step together with status.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_stall/in_data carry one request per tick or command: the
//   command code, the pedal level and the reply to the query that this step
//   names. out_valid/out_stall/out_data return exactly one result per request.
//   cfg_we/cfg_index/cfg_data write line_range, rotation_range and
//   speed_scale; write them only while no request is in flight.
// Pipeline and throughput
//   a request is first held in the request register and then loaded into
//   the result register, where it can be taken; one request per cycle is
//   sustained while out_stall is low. The request register and the result
//   register are the only two stages, and the sequencer state is updated at
//   the edge that loads the result register.
// Reset
//   arst_n low clears both stages, idles the sequencer at the first phase
//   with the needle heading forward, zeroes the stored temperatures and
//   loads the default configuration (750, 92000, 5).
// Stall
//   while out_stall holds, the result stays put and one more request can
//   still be taken into the request register; after that in_stall rises.
// ----------------------------------------------------------------------------
module stitch_cycle_sequencer_unit import scs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  scs_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output scs_out_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	scs_cfg_t   cfg_q;
	scs_state_t st_q;
	scs_state_t st_nxt;

	// request stage
	logic    valid_s1;
	scs_in_t req_s1;

	// result stage
	logic     valid_s2;
	scs_out_t res_s2;
	scs_out_t res_nxt;

	logic advance;
	logic in_take;

	// the request stage moves on whenever the result register is free or emptying
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && valid_s2 && out_stall;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_range     <= LINE_RANGE_RST;
			cfg_q.rotation_range <= ROTATION_RANGE_RST;
			cfg_q.speed_scale    <= SPEED_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LINE_RANGE:     cfg_q.line_range     <= cfg_data;
				CFG_ROTATION_RANGE: cfg_q.rotation_range <= cfg_data;
				CFG_SPEED_SCALE:    cfg_q.speed_scale    <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1 <= in_data;
		end
	end

	// one full step per request
	scs_step u_step (
		.cfg (cfg_q),
		.cur (st_q),
		.req (req_s1),
		.nxt (st_nxt),
		.res (res_nxt)
	);

	// sequencer state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase        <= PH_FIND_JAW;
			st_q.needle_fwd   <= 1'b1;
			st_q.armed        <= 1'b0;
			st_q.stop_pending <= 1'b0;
			st_q.running      <= 1'b0;
			st_q.single_mode  <= 1'b0;
			st_q.jaw_temp     <= '0;
			st_q.needle_temp  <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule
